### design/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared sizes, codes and types of the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;

  // slot index width and width of a slot count (0..TABLE_SLOTS)
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int SIZE_W = $clog2(TABLE_SLOTS + 1);
  // width of the table size register as written
  localparam int CFG_W  = 11;

  typedef enum logic [0:0] {
    OP_FIND   = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISS      = 2'd1,
    ST_EMPTY_KEY = 2'd2,
    ST_BAD_HOME  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE
  } state_e;

endpackage

### design/oaht_if.sv
// ----------------------------------------------------------------------------
// oaht_if
// Request and response channels of the hash table, valid/ready handshake.
// ----------------------------------------------------------------------------
interface oaht_req_if
  import oaht_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  op_e                     op;
  logic [SLOT_W-1:0]       home_slot;
  logic [KEY_BITS-1:0]     lookup_key;
  logic [VALUE_BITS-1:0]   new_value;

  modport source (output valid, op, home_slot, lookup_key, new_value, input ready);
  modport sink   (input valid, op, home_slot, lookup_key, new_value, output ready);
endinterface

interface oaht_rsp_if
  import oaht_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  status_e                 status;
  logic [SLOT_W-1:0]       slot;
  logic [VALUE_BITS-1:0]   stored_value;

  modport source (output valid, status, slot, stored_value, input ready);
  modport sink   (input valid, status, slot, stored_value, output ready);
endinterface

### design/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Linear-probing hash table: find or insert a key from a caller-hashed home slot.
// ----------------------------------------------------------------------------
// result path: a rejected item (empty-marker key, bad home slot) is loaded into the
//   output register as it is accepted; any other item probes until a hit or a full pass
// throughput: one item at a time, accepted only while idle; one key/value memory read
//   per probe cycle sets the pace
// reset: size register to 1024, then a clearing pass writes the empty marker to every
//   key slot while no item is accepted
module open_addressing_hash_table
  import oaht_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  oaht_req_if.sink         req_i,
  oaht_rsp_if.source       rsp_o
);

  localparam logic [KEY_BITS-1:0] EMPTY_KEY = '1;
  localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  // key and value stores, one read port and one write port each
  logic [KEY_BITS-1:0]   key_mem [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] val_mem [TABLE_SLOTS];

  state_e                state_q, state_d;
  logic [SIZE_W-1:0]     size_q;
  logic [SLOT_W-1:0]     clr_q, clr_d;
  logic [SLOT_W-1:0]     cur_q, cur_d;
  logic [SIZE_W-1:0]     n_q, n_d;

  // item held while probing
  op_e                   op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  // memory port controls
  logic                  rd_en;
  logic [SLOT_W-1:0]     rd_addr;
  logic [KEY_BITS-1:0]   rd_key_q;
  logic [VALUE_BITS-1:0] rd_val_q;
  logic                  key_we;
  logic [SLOT_W-1:0]     wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic                  val_we;

  // output register
  logic                  rsp_valid_q, rsp_valid_d;
  status_e               status_q, status_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  rsp_load;

  logic                  out_free;
  logic                  take;
  logic                  hit;
  logic                  last_probe;
  logic [SLOT_W-1:0]     cur_next;

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign take        = req_i.valid && req_i.ready;

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.slot         = slot_q;
  assign rsp_o.stored_value = value_q;

  // compare on the registered read of the current slot
  assign hit = (rd_key_q == key_q) || ((op_q == OP_INSERT) && (rd_key_q == EMPTY_KEY));
  // this probe is the last one of a full pass
  assign last_probe = (n_q + SIZE_W'(1)) == size_q;
  // linear step with wrap at the slots in use
  assign cur_next = ((SIZE_W'(cur_q) + SIZE_W'(1)) == size_q) ? '0 : cur_q + SLOT_W'(1);

  // table size register, zero reads as one slot, large values saturate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_W'(TABLE_SLOTS);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        size_q <= SIZE_W'(1);
      end else if (32'(cfg_wdata_i) > 32'(TABLE_SLOTS)) begin
        size_q <= SIZE_W'(TABLE_SLOTS);
      end else begin
        size_q <= SIZE_W'(cfg_wdata_i);
      end
    end
  end

  // sequencer: clear sweep, idle, one probe per cycle, a final probe held while the output register is full
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cur_d    = cur_q;
    n_d      = n_q;
    rd_en    = 1'b0;
    rd_addr  = cur_next;
    key_we   = 1'b0;
    val_we   = 1'b0;
    wr_addr  = cur_q;
    wr_key   = key_q;
    rsp_load = 1'b0;
    status_d = ST_OK;
    slot_d   = '0;
    value_d  = '0;

    case (state_q)
      S_CLEAR: begin
        key_we  = 1'b1;
        wr_addr = clr_q;
        wr_key  = EMPTY_KEY;
        clr_d   = clr_q + SLOT_W'(1);
        if (clr_q == LAST_SLOT) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          if (req_i.lookup_key == EMPTY_KEY) begin
            rsp_load = 1'b1;
            status_d = ST_EMPTY_KEY;
          end else if (32'(req_i.home_slot) >= 32'(size_q)) begin
            rsp_load = 1'b1;
            status_d = ST_BAD_HOME;
          end else begin
            rd_en   = 1'b1;
            rd_addr = req_i.home_slot;
            cur_d   = req_i.home_slot;
            n_d     = '0;
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (hit) begin
          // finish only when the output register can take the result
          if (out_free) begin
            rsp_load = 1'b1;
            status_d = ST_OK;
            slot_d   = cur_q;
            if (op_q == OP_INSERT) begin
              key_we  = 1'b1;
              val_we  = 1'b1;
              value_d = val_q;
            end else begin
              value_d = rd_val_q;
            end
            state_d = S_IDLE;
          end
        end else if (last_probe) begin
          if (out_free) begin
            rsp_load = 1'b1;
            status_d = ST_MISS;
            state_d  = S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_next;
          cur_d   = cur_next;
          n_d     = n_q + SIZE_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_valid_d = rsp_load ? 1'b1 : (rsp_valid_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      n_q         <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_q       <= cur_d;
      n_q         <= n_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // item and result payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q  <= req_i.op;
      key_q <= req_i.lookup_key;
      val_q <= req_i.new_value;
    end
    if (rsp_load) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      value_q  <= value_d;
    end
  end

  // key store
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (rd_en) begin
      rd_key_q <= key_mem[rd_addr];
    end
  end

  // value store
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[wr_addr] <= val_q;
    end
    if (rd_en) begin
      rd_val_q <= val_mem[rd_addr];
    end
  end

  // probe position and count stay inside the slots in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> ((n_q < size_q) && (SIZE_W'(cur_q) < size_q)))
    else $error("probe position or count beyond table size");

  // no item is taken during the clearing sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !req_i.ready)
    else $error("item accepted while clearing");

  // a failed item carries zero slot and value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (status_q != ST_OK)) |-> ((slot_q == '0) && (value_q == '0)))
    else $error("nonzero payload on failed item");

  // a loaded result always comes from a leaving probe or from idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> (state_q == S_IDLE))
    else $error("result loaded without returning to idle");

endmodule

### dv/open_addressing_hash_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table_tb
// Self-checking bench for the linear-probing hash table. A directed table
// covers the rejected keys, bad home slots, wrap-around, a full table and
// the size register extremes; random phases then run small key pools
// against changing table sizes. Results are compared with a shadow copy
// of the key and value stores, or with the expected result typed in a row.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_tb;
  import oaht_pkg::*;

  localparam logic [KEY_BITS-1:0] EMPTY_KEY = '1;
  localparam int RANDOM_ITEMS = 1850;
  // random items after which both sides stop idling
  localparam int QUIET_AFTER  = 1650;
  localparam int MAX_POOL     = 64;

  // one expected item on the response channel
  typedef struct packed {
    status_e                 status;
    logic [SLOT_W-1:0]       slot;
    logic [VALUE_BITS-1:0]   value;
  } lookup_result_t;

  // one row of the directed table: a size write or a request
  typedef struct packed {
    bit                      is_cfg;
    logic [CFG_W-1:0]        size;
    op_e                     op;
    logic [SLOT_W-1:0]       home;
    logic [KEY_BITS-1:0]     key;
    logic [VALUE_BITS-1:0]   value;
    bit                      fixed;     // expected result typed in below
    status_e                 status;
    logic [SLOT_W-1:0]       slot;
    logic [VALUE_BITS-1:0]   stored;
  } stim_row_t;

  localparam int N_DIR = 27;
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    // fresh table at 1024 slots: find misses after a full pass
    '{1'b0, 11'd0, OP_FIND,   10'd0,    32'h0000_0000, 32'h0,  1'b1, ST_MISS,      10'd0,    32'h0},
    // empty marker rejected for find and insert
    '{1'b0, 11'd0, OP_FIND,   10'd0,    32'hFFFF_FFFF, 32'h0,  1'b1, ST_EMPTY_KEY, 10'd0,    32'h0},
    '{1'b0, 11'd0, OP_INSERT, 10'd1023, 32'hFFFF_FFFF, 32'h1,  1'b1, ST_EMPTY_KEY, 10'd0,    32'h0},
    // top slot, extreme value
    '{1'b0, 11'd0, OP_INSERT, 10'd1023, 32'h0000_0000, 32'hFFFF_FFFF,
      1'b1, ST_OK, 10'd1023, 32'hFFFF_FFFF},
    '{1'b0, 11'd0, OP_FIND,   10'd0,    32'h0000_0000, 32'h0,  1'b0, ST_OK, 10'd0, 32'h0},
    // overwrite in place
    '{1'b0, 11'd0, OP_INSERT, 10'd1023, 32'h0000_0000, 32'h0,  1'b0, ST_OK, 10'd0, 32'h0},
    // top slot taken, wraps to slot 0
    '{1'b0, 11'd0, OP_INSERT, 10'd1023, 32'hFFFF_FFFE, 32'hDEAD_BEEF,
      1'b0, ST_OK, 10'd0, 32'h0},
    '{1'b0, 11'd0, OP_FIND,   10'd1023, 32'hFFFF_FFFE, 32'h0,  1'b0, ST_OK, 10'd0, 32'h0},
    '{1'b1, 11'd4, OP_FIND,   10'd0,    32'h0,         32'h0,  1'b0, ST_OK, 10'd0, 32'h0},
    // home slot at and far above the size
    '{1'b0, 11'd0, OP_FIND,   10'd4,    32'h0000_0001, 32'h0,  1'b1, ST_BAD_HOME,  10'd0,    32'h0},
    '{1'b0, 11'd0, OP_INSERT, 10'd1023, 32'h0000_0001, 32'h7,  1'b1, ST_BAD_HOME,  10'd0,    32'h0},
    // empty marker wins over a bad home slot
    '{1'b0, 11'd0, OP_INSERT, 10'd4,    32'hFFFF_FFFF, 32'h7,  1'b1, ST_EMPTY_KEY, 10'd0,    32'h0},
    // fill the three free slots, then one more insert finds the table full
    '{1'b0, 11'd0, OP_INSERT, 10'd3,    32'h0000_0010, 32'h10, 1'b0, ST_OK, 10'd0, 32'h0},
    '{1'b0, 11'd0, OP_INSERT, 10'd3,    32'h0000_0011, 32'h11, 1'b0, ST_OK, 10'd0, 32'h0},
    '{1'b0, 11'd0, OP_INSERT, 10'd2,    32'h0000_0012, 32'h12, 1'b0, ST_OK, 10'd0, 32'h0},
    '{1'b0, 11'd0, OP_INSERT, 10'd0,    32'h0000_0013, 32'h13, 1'b0, ST_OK, 10'd0, 32'h0},
    '{1'b0, 11'd0, OP_FIND,   10'd1,    32'h0000_0099, 32'h0,  1'b0, ST_OK, 10'd0, 32'h0},
    // size zero behaves as one slot
    '{1'b1, 11'd0, OP_FIND,   10'd0,    32'h0,         32'h0,  1'b0, ST_OK, 10'd0, 32'h0},
    '{1'b0, 11'd0, OP_FIND,   10'd1,    32'h0000_0000, 32'h0,  1'b1, ST_BAD_HOME,  10'd0,    32'h0},
    '{1'b0, 11'd0, OP_FIND,   10'd0,    32'hFFFF_FFFE, 32'h0,  1'b0, ST_OK, 10'd0, 32'h0},
    // all-ones size saturates to the full table
    '{1'b1, 11'd2047, OP_FIND, 10'd0,   32'h0,         32'h0,  1'b0, ST_OK, 10'd0, 32'h0},
    '{1'b0, 11'd0, OP_FIND,   10'd1023, 32'h0000_0000, 32'h0,  1'b0, ST_OK, 10'd0, 32'h0},
    // shrink: slot 2 keeps its key but is out of reach
    '{1'b1, 11'd2, OP_FIND,   10'd0,    32'h0,         32'h0,  1'b0, ST_OK, 10'd0, 32'h0},
    '{1'b0, 11'd0, OP_FIND,   10'd0,    32'h0000_0012, 32'h0,  1'b0, ST_OK, 10'd0, 32'h0},
    '{1'b1, 11'd1024, OP_FIND, 10'd0,   32'h0,         32'h0,  1'b0, ST_OK, 10'd0, 32'h0},
    '{1'b0, 11'd0, OP_FIND,   10'd0,    32'h0000_0012, 32'h0,  1'b0, ST_OK, 10'd0, 32'h0},
    '{1'b0, 11'd0, OP_INSERT, 10'd512,  32'h8000_0000, 32'h5555_5555,
      1'b0, ST_OK, 10'd0, 32'h0}
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;

  oaht_req_if req_if ();
  oaht_rsp_if rsp_if ();

  open_addressing_hash_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // shadow copy of the table
  logic [KEY_BITS-1:0]   shadow_keys   [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] shadow_values [TABLE_SLOTS];
  logic [CFG_W-1:0]      shadow_size;

  lookup_result_t pending_results [$];
  int unsigned    error_count;
  bit             quiet;   // no idling on either side

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

  // number of slots actually probed for a given register value
  function automatic int unsigned slots_in_use(logic [CFG_W-1:0] size);
    if (size == 0) return 1;
    if (size > TABLE_SLOTS) return TABLE_SLOTS;
    return 32'(size);
  endfunction

  // linear probe on the shadow table, updates it on insert
  function automatic lookup_result_t probe_shadow(op_e op, logic [SLOT_W-1:0] home,
                                                  logic [KEY_BITS-1:0] key,
                                                  logic [VALUE_BITS-1:0] value);
    lookup_result_t res;
    int unsigned    span;
    int unsigned    cur;
    span       = slots_in_use(shadow_size);
    res.status = ST_MISS;
    res.slot   = '0;
    res.value  = '0;
    if (key == EMPTY_KEY) begin
      res.status = ST_EMPTY_KEY;
      return res;
    end
    if (home >= span) begin
      res.status = ST_BAD_HOME;
      return res;
    end
    cur = 32'(home);
    for (int unsigned n = 0; n < span; n++) begin
      if (shadow_keys[cur] == key || (op == OP_INSERT && shadow_keys[cur] == EMPTY_KEY)) begin
        if (op == OP_INSERT) begin
          shadow_keys[cur]   = key;
          shadow_values[cur] = value;
        end
        res.status = ST_OK;
        res.slot   = cur[SLOT_W-1:0];
        res.value  = shadow_values[cur];
        return res;
      end
      cur++;
      if (cur >= span) cur = 0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < 40)
      $display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // send one request; a random gap may precede it
  task automatic send_request(op_e op, logic [SLOT_W-1:0] home, logic [KEY_BITS-1:0] key,
                              logic [VALUE_BITS-1:0] value, bit fixed,
                              lookup_result_t fixed_res);
    lookup_result_t res;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.home_slot  <= home;
    req_if.lookup_key <= key;
    req_if.new_value  <= value;
    do @(posedge clk); while (!req_if.ready);
    // accepted at this edge; shadow table always follows the item
    res = probe_shadow(op, home, key, value);
    pending_results.push_back(fixed ? fixed_res : res);
  endtask

  // size write, only once the block has drained
  task automatic write_table_size(logic [CFG_W-1:0] size);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    shadow_size = size;
    cfg_we    <= 1'b0;
  endtask

  // response side: random stall bursts
  initial begin
    int unsigned hold;
    hold = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 14) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", 64'({rsp_if.status, rsp_if.slot}), 64'(0));
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
        if (rsp_if.slot !== want.slot)
          report_mismatch("slot", 64'(rsp_if.slot), 64'(want.slot));
        if (rsp_if.stored_value !== want.value)
          report_mismatch("stored_value", 64'(rsp_if.stored_value), 64'(want.value));
      end
    end
  end

  initial begin
    lookup_result_t        fixed_res;
    logic [KEY_BITS-1:0]   key_pool [MAX_POOL];
    logic [KEY_BITS-1:0]   key;
    logic [SLOT_W-1:0]     home;
    logic [CFG_W-1:0]      size;
    op_e                   op;
    int unsigned           span;
    int unsigned           pool_len;
    int unsigned           phase_len;
    int unsigned           sent;
    int unsigned           pick;

    for (int i = 0; i < TABLE_SLOTS; i++) begin
      shadow_keys[i]   = EMPTY_KEY;
      shadow_values[i] = '0;
    end
    shadow_size = 11'd1024;
    error_count = 0;
    quiet       = 1'b0;
    sent        = 0;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_if.valid      = 1'b0;
    req_if.op         = OP_FIND;
    req_if.home_slot  = '0;
    req_if.lookup_key = '0;
    req_if.new_value  = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // the clearing pass holds ready low; send_request just waits on it

    // directed table
    for (int r = 0; r < N_DIR; r++) begin
      if (DIR_ROWS[r].is_cfg) begin
        write_table_size(DIR_ROWS[r].size);
      end else begin
        fixed_res.status = DIR_ROWS[r].status;
        fixed_res.slot   = DIR_ROWS[r].slot;
        fixed_res.value  = DIR_ROWS[r].stored;
        send_request(DIR_ROWS[r].op, DIR_ROWS[r].home, DIR_ROWS[r].key,
                     DIR_ROWS[r].value, DIR_ROWS[r].fixed, fixed_res);
      end
    end

    // random phases: one table size and one key pool per phase
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)       size = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
      else if (pick < 8)  size = 11'd0;
      else if (pick < 14) size = 11'd1;
      else if (pick < 20) size = 11'd2;
      else if (pick < 80) size = CFG_W'($urandom_range(3, 32));
      else                size = CFG_W'($urandom_range(33, 200));
      write_table_size(size);
      span = slots_in_use(size);

      // a few more keys than slots so small tables run full
      pool_len = (span + 3 < MAX_POOL) ? span + 3 : MAX_POOL;
      for (int k = 0; k < MAX_POOL; k++) begin
        key_pool[k] = $urandom;
        if (key_pool[k] == EMPTY_KEY) key_pool[k] = '0;
      end
      if ($urandom_range(0, 3) == 0) key_pool[0] = '0;
      if ($urandom_range(0, 3) == 0) key_pool[1] = EMPTY_KEY - 1;

      phase_len = (span >= 512) ? 25 : $urandom_range(20, 60);
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        op   = $urandom_range(0, 1) ? OP_INSERT : OP_FIND;
        key  = key_pool[$urandom_range(0, pool_len - 1)];
        home = SLOT_W'($urandom_range(0, span - 1));
        if (pick < 6) begin
          // home slot out of range, or anywhere when the table is full size
          home = (span < TABLE_SLOTS) ? SLOT_W'($urandom_range(span, TABLE_SLOTS - 1))
                                      : SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
        end else if (pick < 9) begin
          key  = EMPTY_KEY;
          home = SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
        end else if (pick < 19) begin
          // key never seen, mostly a miss on find
          key = $urandom;
        end
        send_request(op, home, key, $urandom, 1'b0, fixed_res);
        sent++;
        quiet = (sent >= QUIET_AFTER);
      end
    end

    // drain and let the output settle
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
